[rtl/core/hpv_pkg.sv]
// Package for the plane vote engine: sizes, codes, command types and trig tables.
`timescale 1ns / 1ps
package hpv_pkg;

    // Accumulator geometry.
    localparam int AZIM_BINS          = 64;
    localparam int POLAR_BINS         = 32;
    localparam int RANGE_BINS         = 32;
    localparam int TRIG_FRACTION_BITS = 15;

    localparam int TB     = $clog2(AZIM_BINS);
    localparam int PB     = $clog2(POLAR_BINS);
    localparam int PLANE  = AZIM_BINS * POLAR_BINS;
    localparam int CELLS  = PLANE * RANGE_BINS;
    localparam int AW     = $clog2(CELLS);
    localparam int PHI_DEN = 2 * POLAR_BINS;

    // Datapath widths.
    localparam int CW    = 20;
    localparam int TW    = TRIG_FRACTION_BITS + 2;
    localparam int NW    = 2 * TRIG_FRACTION_BITS + 2;
    localparam int DW    = CW + NW + 2;
    localparam int SHIFT = 2 * TRIG_FRACTION_BITS - 8;
    localparam int RW    = DW - SHIFT;
    localparam int C8W   = 30;
    localparam int DFW   = ((DW > C8W + SHIFT + 1) ? DW : C8W + SHIFT + 1) + 1;
    localparam int LIMW  = 16 + 2 * TRIG_FRACTION_BITS;
    localparam int CMPW  = (DFW > LIMW) ? DFW : LIMW;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Register reset values.
    localparam logic [31:0] RHO_SCALE_RST  = 32'd83886;
    localparam logic [23:0] RHO_STEP_RST   = 24'd51200;
    localparam logic [15:0] DIST_LIM_RST   = 16'd10;
    localparam logic [15:0] PEAK_RATIO_RST = 16'd49152;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    typedef enum logic [1:0] {
        OP_VOTE  = 2'd0,
        OP_READ  = 2'd1,
        OP_TEST  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_RHO_SCALE  = 2'd0,
        CFG_RHO_STEP   = 2'd1,
        CFG_DIST_LIMIT = 2'd2,
        CFG_PEAK_RATIO = 2'd3
    } t_cfg_idx;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [TW-1:0] t_trig;
    typedef t_trig t_theta_tab [AZIM_BINS];
    typedef t_trig t_phi_tab [POLAR_BINS];

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          latch;
        logic          issue;
        logic [TB-1:0] t_idx;
        logic [PB-1:0] p_idx;
        logic          clr_we;
        logic [AW-1:0] clr_addr;
        logic          max_clr;
        logic          out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
    } t_dp_stat;

    // Clamp to [0, 1.0] in Q30 and round half up to the table precision.
    function automatic longint round_trig(longint v);
        longint w;
        w = v;
        if (w < 0) w = 0;
        if (w > ONE_Q30) w = ONE_Q30;
        return (w + (64'sd1 <<< (29 - TRIG_FRACTION_BITS))) >>> (30 - TRIG_FRACTION_BITS);
    endfunction

    // Taylor sine and cosine of a Q30 angle in the first quadrant, quadrant signs applied.
    function automatic longint trig_val(longint unsigned x, bit want_cos, int unsigned q);
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint s;
        longint c;
        longint sv;
        longint cv;
        longint res;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        s  = longint'(x);
        c  = ONE_Q30;
        ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;
        s  = s - longint'(ts);        c  = c - longint'(tc);
        ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;
        s  = s + longint'(ts);        c  = c + longint'(tc);
        ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;
        s  = s - longint'(ts);        c  = c - longint'(tc);
        ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;
        s  = s + longint'(ts);        c  = c + longint'(tc);
        ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;
        s  = s - longint'(ts);        c  = c - longint'(tc);
        ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132;
        s  = s + longint'(ts);        c  = c + longint'(tc);
        sv = round_trig(s);
        cv = round_trig(c);
        case (q & 3)
            0:       res = want_cos ? cv : sv;
            1:       res = want_cos ? -sv : cv;
            2:       res = want_cos ? -cv : -sv;
            default: res = want_cos ? sv : -cv;
        endcase
        return res;
    endfunction

    // Azimuth table, angle 2*pi*i/AZIM_BINS; evaluated at elaboration.
    function automatic t_theta_tab build_theta(bit want_cos);
        t_theta_tab      tab;
        int unsigned     four;
        int unsigned     q;
        int unsigned     r;
        longint unsigned x;
        for (int i = 0; i < AZIM_BINS; i++) begin
            four   = 4 * i;
            q      = four / AZIM_BINS;
            r      = four - q * AZIM_BINS;
            x      = (HALF_PI_Q30 * longint'(r)) / AZIM_BINS;
            tab[i] = TW'(trig_val(x, want_cos, q));
        end
        return tab;
    endfunction

    // Polar table, angle pi*i/POLAR_BINS; evaluated at elaboration.
    function automatic t_phi_tab build_phi(bit want_cos);
        t_phi_tab        tab;
        int unsigned     four;
        int unsigned     q;
        int unsigned     r;
        longint unsigned x;
        for (int i = 0; i < POLAR_BINS; i++) begin
            four   = 4 * i;
            q      = four / PHI_DEN;
            r      = four - q * PHI_DEN;
            x      = (HALF_PI_Q30 * longint'(r)) / PHI_DEN;
            tab[i] = TW'(trig_val(x, want_cos, q));
        end
        return tab;
    endfunction

    localparam t_theta_tab SIN_THETA = build_theta(1'b0);
    localparam t_theta_tab COS_THETA = build_theta(1'b1);
    localparam t_phi_tab   SIN_PHI   = build_phi(1'b0);
    localparam t_phi_tab   COS_PHI   = build_phi(1'b1);

endpackage

[rtl/core/hpv_if.sv]
// Channel interfaces of the plane vote engine: item, result and register write.
`timescale 1ns / 1ps
interface hpv_item_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           op;
    logic signed [19:0]   x_mm;
    logic signed [19:0]   y_mm;
    logic signed [19:0]   z_mm;
    logic [5:0]           azim_idx;
    logic [4:0]           polar_idx;
    logic [5:0]           range_idx;
    modport source(output valid, op, x_mm, y_mm, z_mm, azim_idx, polar_idx, range_idx,
                   input ready);
    modport sink(input valid, op, x_mm, y_mm, z_mm, azim_idx, polar_idx, range_idx,
                 output ready);
endinterface

interface hpv_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_votes;
    logic [15:0] peak_votes;
    logic        is_peak;
    logic        on_plane;
    modport source(output valid, cell_votes, peak_votes, is_peak, on_plane, input ready);
    modport sink(input valid, cell_votes, peak_votes, is_peak, on_plane, output ready);
endinterface

interface hpv_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[rtl/core/hpv_dp.sv]
// Datapath: registers, trig lookup, dot product pipeline, vote store and result registers.
`timescale 1ns / 1ps
module hpv_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hpv_pkg::t_op      i_op,
    input  hpv_pkg::t_coord   i_x,
    input  hpv_pkg::t_coord   i_y,
    input  hpv_pkg::t_coord   i_z,
    input  logic [5:0]        i_theta,
    input  logic [4:0]        i_phi,
    input  logic [5:0]        i_rho,
    input  logic              i_cfg_we,
    input  hpv_pkg::t_cfg_idx i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  hpv_pkg::t_dp_cmd  i_cmd,
    output hpv_pkg::t_dp_stat o_stat,
    output logic [15:0]       o_cell_votes,
    output logic [15:0]       o_peak_votes,
    output logic              o_is_peak,
    output logic              o_on_plane
);
    import hpv_pkg::*;

    logic [31:0] r_rho_scale;
    logic [23:0] r_rho_step;
    logic [15:0] r_dist_lim;
    logic [15:0] r_peak_ratio;

    t_op          r_op;
    t_coord       r_x, r_y, r_z;
    logic [5:0]   r_ti;
    logic [4:0]   r_pi;
    logic [5:0]   r_ri;
    logic         r_in_range;
    logic [C8W-1:0] r_c8;

    logic [TB-1:0] t_sel;
    logic [PB-1:0] p_sel;
    logic signed [2*TW-1:0] w_nx, w_ny;

    logic                 r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    logic [TB-1:0]        r_s1_t, r_s2_t, r_s3_t, r_s4_t, r_s5_t;
    logic [PB-1:0]        r_s1_p, r_s2_p, r_s3_p, r_s4_p, r_s5_p;
    logic signed [NW-1:0] r_nx, r_ny, r_nz;
    logic signed [CW+NW-1:0] w_px, w_py, w_pz, r_px, r_py, r_pz;
    logic signed [DW-1:0] r_dot;
    logic [DW-1:0]        w_mag;
    logic [RW-1:0]        r_r8;
    logic signed [DFW-1:0] w_dot_x, w_c, r_diff;
    logic [DFW-1:0]       w_dmag;
    logic [LIMW-1:0]      w_lim;
    logic [RW+31:0]       w_prod;
    logic [RW-1:0]        r_bin;
    logic                 r_s5_onp, r_s6_onp;
    logic                 w_hit;
    logic [AW-1:0]        w_vaddr, w_caddr, w_raddr;
    logic                 r_s6_hit;
    logic [AW-1:0]        r_s6_addr;

    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rdata;
    logic [15:0]   n_cnt;
    logic          w_vote_we, w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [15:0]   r_max;
    logic [31:0]   w_thr_full;
    logic [15:0]   r_votes;
    logic          r_peak, r_onp;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rho_scale  <= RHO_SCALE_RST;
            r_rho_step   <= RHO_STEP_RST;
            r_dist_lim   <= DIST_LIM_RST;
            r_peak_ratio <= PEAK_RATIO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RHO_SCALE:  r_rho_scale  <= i_cfg_data;
                CFG_RHO_STEP:   r_rho_step   <= i_cfg_data[23:0];
                CFG_DIST_LIMIT: r_dist_lim   <= i_cfg_data[15:0];
                CFG_PEAK_RATIO: r_peak_ratio <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Item registers, with the range check and cell distance worked out once.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op       <= i_op;
            r_x        <= i_x;
            r_y        <= i_y;
            r_z        <= i_z;
            r_ti       <= i_theta;
            r_pi       <= i_phi;
            r_ri       <= i_rho;
            r_in_range <= (int'(i_theta) < AZIM_BINS) && (int'(i_phi) < POLAR_BINS) &&
                          (int'(i_rho) < RANGE_BINS);
            r_c8       <= C8W'(i_rho) * C8W'(r_rho_step);
        end
    end

    // Stage 1: normal vector from the trig tables.
    assign t_sel = (r_op == OP_VOTE) ? i_cmd.t_idx : TB'(r_ti);
    assign p_sel = (r_op == OP_VOTE) ? i_cmd.p_idx : PB'(r_pi);
    assign w_nx  = SIN_PHI[p_sel] * COS_THETA[t_sel];
    assign w_ny  = SIN_PHI[p_sel] * SIN_THETA[t_sel];

    always_ff @(posedge i_clk) begin
        r_nx   <= w_nx[NW-1:0];
        r_ny   <= w_ny[NW-1:0];
        r_nz   <= NW'(COS_PHI[p_sel]) <<< TRIG_FRACTION_BITS;
        r_s1_t <= t_sel;
        r_s1_p <= p_sel;
    end

    // Stage 2: coordinate products.
    assign w_px = r_x * r_nx;
    assign w_py = r_y * r_ny;
    assign w_pz = r_z * r_nz;

    always_ff @(posedge i_clk) begin
        r_px   <= w_px;
        r_py   <= w_py;
        r_pz   <= w_pz;
        r_s2_t <= r_s1_t;
        r_s2_p <= r_s1_p;
    end

    // Stage 3: dot product.
    always_ff @(posedge i_clk) begin
        r_dot  <= DW'(r_px) + DW'(r_py) + DW'(r_pz);
        r_s3_t <= r_s2_t;
        r_s3_p <= r_s2_p;
    end

    // Stage 4: magnitude in Q8 mm, and signed offset from the cell plane.
    assign w_mag   = r_dot[DW-1] ? DW'(-r_dot) : DW'(r_dot);
    assign w_dot_x = DFW'(r_dot);
    assign w_c     = signed'(DFW'({r_c8, {SHIFT{1'b0}}}));

    always_ff @(posedge i_clk) begin
        r_r8   <= w_mag[DW-1:SHIFT];
        r_diff <= w_dot_x - w_c;
        r_s4_t <= r_s3_t;
        r_s4_p <= r_s3_p;
    end

    // Stage 5: rho bin and plane membership.
    assign w_prod = r_r8 * r_rho_scale;
    assign w_dmag = r_diff[DFW-1] ? DFW'(-r_diff) : DFW'(r_diff);
    assign w_lim  = {r_dist_lim, {(2 * TRIG_FRACTION_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        r_bin    <= w_prod[RW+31:32];
        r_s5_onp <= CMPW'(w_dmag) < CMPW'(w_lim);
        r_s5_t   <= r_s4_t;
        r_s5_p   <= r_s4_p;
    end

    // Stage 6: cell address and store read.
    assign w_hit   = (r_op == OP_VOTE) && (r_bin < RW'(RANGE_BINS));
    assign w_vaddr = AW'(AW'(r_bin) * AW'(PLANE) + AW'(r_s5_t) * AW'(POLAR_BINS) + AW'(r_s5_p));
    assign w_caddr = AW'(AW'(r_ri) * AW'(PLANE) + AW'(r_ti) * AW'(POLAR_BINS) + AW'(r_pi));
    assign w_raddr = (r_op == OP_VOTE) ? w_vaddr : w_caddr;

    always_ff @(posedge i_clk) begin
        r_s6_hit  <= r_s5_v && w_hit;
        r_s6_addr <= w_raddr;
        r_s6_onp  <= r_s5_onp;
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    assign o_stat.busy = r_s1_v | r_s2_v | r_s3_v | r_s4_v | r_s5_v | r_s6_v;

    // Stage 7: saturating increment written back; clearing pass shares the port.
    assign n_cnt     = (r_rdata == CNT_MAX) ? r_rdata : r_rdata + 16'd1;
    assign w_vote_we = r_s6_v && r_s6_hit;
    assign w_we      = w_vote_we || i_cmd.clr_we;
    assign w_waddr   = i_cmd.clr_we ? i_cmd.clr_addr : r_s6_addr;
    assign w_wdata   = i_cmd.clr_we ? 16'd0 : n_cnt;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Largest count seen.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 16'd0;
        end else if (i_cmd.max_clr) begin
            r_max <= 16'd0;
        end else if (w_vote_we && (n_cnt > r_max)) begin
            r_max <= n_cnt;
        end
    end

    // Per-item results for read and test.
    assign w_thr_full = r_peak_ratio * r_max;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_votes <= 16'd0;
            r_peak  <= 1'b0;
            r_onp   <= 1'b0;
        end else if (r_s6_v) begin
            if (r_op == OP_READ) begin
                r_votes <= r_in_range ? r_rdata : 16'd0;
                r_peak  <= r_in_range && (r_rdata >= w_thr_full[31:16]);
            end
            if (r_op == OP_TEST) begin
                r_onp <= r_in_range && !r_c8[C8W-1] && r_s6_onp;
            end
        end
    end

    // Output register, loaded when the result slot is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_cell_votes <= r_votes;
            o_peak_votes <= r_max;
            o_is_peak    <= r_peak;
            o_on_plane   <= r_onp;
        end
    end

endmodule

[rtl/core/hpv_ctrl.sv]
// Controller: sequences clearing passes, vote sweeps, single lookups and the result handoff.
`timescale 1ns / 1ps
module hpv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  hpv_pkg::t_op      i_op,
    input  logic              i_pt_zero,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hpv_pkg::t_dp_cmd  o_cmd,
    input  hpv_pkg::t_dp_stat i_stat
);
    import hpv_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SWEEP = 6'b000100,
        ST_ONE   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_clr_op, n_clr_op;
    logic [TB-1:0] r_t, n_t;
    logic [PB-1:0] r_p, n_p;
    logic          r_out_valid, n_out_valid;
    logic          w_accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_clr_op       = r_clr_op;
        n_t            = r_t;
        n_p            = r_p;
        o_cmd          = '0;
        o_cmd.t_idx    = r_t;
        o_cmd.p_idx    = r_p;
        o_cmd.clr_addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                n_clr_addr   = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(CELLS - 1)) begin
                    n_state = r_clr_op ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.latch = 1'b1;
                    case (i_op)
                        OP_VOTE: begin
                            n_t     = '0;
                            n_p     = '0;
                            n_state = i_pt_zero ? ST_DONE : ST_SWEEP;
                        end
                        OP_READ, OP_TEST: n_state = ST_ONE;
                        OP_CLEAR: begin
                            o_cmd.max_clr = 1'b1;
                            n_clr_addr    = '0;
                            n_clr_op      = 1'b1;
                            n_state       = ST_CLEAR;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SWEEP: begin
                // One theta and phi pair enters the pipeline every cycle.
                o_cmd.issue = 1'b1;
                if (r_p == PB'(POLAR_BINS - 1)) begin
                    n_p = '0;
                    if (r_t == TB'(AZIM_BINS - 1)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_t = r_t + TB'(1);
                    end
                end else begin
                    n_p = r_p + PB'(1);
                end
            end
            ST_ONE: begin
                o_cmd.issue = 1'b1;
                n_state     = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result slot occupancy.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_op    <= 1'b0;
            r_t         <= '0;
            r_p         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_op    <= n_clr_op;
            r_t         <= n_t;
            r_p         <= n_p;
            r_out_valid <= n_out_valid;
        end
    end

    // Only one item is in flight at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("item accepted while another is in flight");

    // A result is handed off only after the pipeline has drained.
    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !i_stat.busy)
        else $error("result handed off with pipeline busy");

    // The clearing pass never overlaps pipeline write-backs.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_we |-> !i_stat.busy)
        else $error("clearing pass overlaps vote traffic");

endmodule

[rtl/core/hough_plane_vote_engine.sv]
// Top level of the plane vote engine: channels, controller and datapath.
// Vote: AZIM_BINS*POLAR_BINS (2048) theta and phi pairs, one per cycle; in-range rho cells gain a vote.
// Read and test: one lookup through the pipeline; clear: zeroes all 65536 cells, then the result.
// A vote of the all-zero point skips the sweep and goes straight to its result; one item at a time.
// After reset a clearing pass zeroes all 65536 cells of the store; items wait, writes go on.
// Reset is synchronous and active low; registers take their documented reset values.
`timescale 1ns / 1ps
module hough_plane_vote_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hpv_item_if.sink     i_item,
    hpv_result_if.source o_result,
    hpv_cfg_if.sink      i_cfg
);
    import hpv_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_pt_zero;
    logic     w_cfg_we;

    // Register writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    assign w_pt_zero = (i_item.x_mm == '0) && (i_item.y_mm == '0) && (i_item.z_mm == '0);

    hpv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_op        (t_op'(i_item.op)),
        .i_pt_zero   (w_pt_zero),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    hpv_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (t_op'(i_item.op)),
        .i_x          (i_item.x_mm),
        .i_y          (i_item.y_mm),
        .i_z          (i_item.z_mm),
        .i_theta      (i_item.azim_idx),
        .i_phi        (i_item.polar_idx),
        .i_rho        (i_item.range_idx),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_idx    (t_cfg_idx'(i_cfg.index)),
        .i_cfg_data   (i_cfg.data),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_cell_votes (o_result.cell_votes),
        .o_peak_votes (o_result.peak_votes),
        .o_is_peak    (o_result.is_peak),
        .o_on_plane   (o_result.on_plane)
    );

endmodule

[sim/hough_plane_vote_engine_tb.sv]
// Self-checking testbench for the plane vote engine: votes, cell reads, plane tests, clears.
`timescale 1ns / 1ps
module hough_plane_vote_engine_tb;
    import hpv_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int HOLD_CYCLES    = 8000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        t_op          op;
        t_coord       x;
        t_coord       y;
        t_coord       z;
        logic [5:0]   t;
        logic [4:0]   p;
        logic [5:0]   r;
    } t_hough_item;

    typedef struct {
        logic [15:0] cell_votes;
        logic [15:0] peak_votes;
        logic        is_peak;
        logic        on_plane;
    } t_hough_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hpv_item_if   item_ch();
    hpv_result_if res_ch();
    hpv_cfg_if    cfg_ch();

    hough_plane_vote_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // Model state: register copies, accumulator, running maximum, trig tables.
    logic [31:0] m_rho_scale;
    logic [23:0] m_rho_step;
    logic [15:0] m_dist_limit;
    logic [15:0] m_peak_ratio;
    logic [15:0] m_votes [CELLS];
    logic [15:0] m_max_count;
    longint      sin_t [AZIM_BINS];
    longint      cos_t [AZIM_BINS];
    longint      sin_p [POLAR_BINS];
    longint      cos_p [POLAR_BINS];

    t_hough_item   pending_items [$];
    t_hough_result expected_results [$];

    int  send_idle;
    int  recv_idle;
    int  hold_req;
    int  hold_grant;
    int  hold_left;
    logic item_took;
    int  mismatches;
    int  n_vote, n_read, n_test, n_clear, n_peak_hits, n_plane_hits;

    // Clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Clamp to [0, 1] in Q30 and round half up to the table precision.
    function automatic longint trig_round(longint v);
        longint w;
        w = v;
        if (w < 0) w = 0;
        if (w > (64'sd1 <<< 30)) w = 64'sd1 <<< 30;
        return (w + (64'sd1 <<< (29 - TRIG_FRACTION_BITS))) >>> (30 - TRIG_FRACTION_BITS);
    endfunction

    // Sine and cosine of 2*pi*num/den from a Taylor series on the reduced quadrant angle.
    task automatic trig_pair(input int unsigned num, input int unsigned den,
                             output longint s_out, output longint c_out);
        int unsigned     quad;
        int unsigned     rem;
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned ts;
        longint unsigned tc;
        longint          s;
        longint          c;
        longint          sv;
        longint          cv;
        quad = (4 * num) / den;
        rem  = 4 * num - quad * den;
        ang  = (64'd1686629713 * rem) / den;
        ang2 = (ang * ang) >> 30;
        ts   = ang;
        tc   = 64'd1 << 30;
        s    = longint'(ang);
        c    = 64'sd1 <<< 30;
        for (int k = 1; k <= 6; k++) begin
            ts = ((ts * ang2) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * ang2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end else begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
        sv = trig_round(s);
        cv = trig_round(c);
        case (quad % 4)
            0: begin s_out = sv;  c_out = cv;  end
            1: begin s_out = cv;  c_out = -sv; end
            2: begin s_out = -sv; c_out = -cv; end
            default: begin s_out = -cv; c_out = sv; end
        endcase
    endtask

    // Point dot normal, exact in Q(2*TRIG_FRACTION_BITS) millimetres.
    function automatic longint plane_dot(t_coord x, t_coord y, t_coord z, int t, int p);
        return longint'(x) * (sin_p[p] * cos_t[t]) + longint'(y) * (sin_p[p] * sin_t[t])
             + longint'(z) * (cos_p[p] <<< TRIG_FRACTION_BITS);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Rho bin a point falls into for one theta and phi under the current scale.
    function automatic longint unsigned rho_bin_of(t_coord x, t_coord y, t_coord z,
                                                   int t, int p);
        longint unsigned r8;
        r8 = longint'(mag(plane_dot(x, y, z, t, p))) >> SHIFT;
        return (r8 * longint'({32'd0, m_rho_scale})) >> 32;
    endfunction

    // Apply one accepted item to the model and queue the result it must produce.
    task automatic predict(input t_hough_item it);
        t_hough_result   e;
        longint unsigned bin;
        longint unsigned thr;
        longint unsigned c8;
        longint          gap;
        int              a;
        bit              in_rng;
        e.cell_votes = '0;
        e.is_peak    = 1'b0;
        e.on_plane   = 1'b0;
        in_rng = (it.t < AZIM_BINS) && (it.p < POLAR_BINS) && (it.r < RANGE_BINS);
        case (it.op)
            OP_VOTE: begin
                n_vote++;
                if (it.x != 0 || it.y != 0 || it.z != 0) begin
                    for (int t = 0; t < AZIM_BINS; t++) begin
                        for (int p = 0; p < POLAR_BINS; p++) begin
                            bin = rho_bin_of(it.x, it.y, it.z, t, p);
                            if (bin < RANGE_BINS) begin
                                a = int'(bin) * PLANE + t * POLAR_BINS + p;
                                if (m_votes[a] != CNT_MAX) m_votes[a] = m_votes[a] + 16'd1;
                                if (m_votes[a] > m_max_count) m_max_count = m_votes[a];
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                n_read++;
                if (in_rng) begin
                    a   = int'(it.r) * PLANE + int'(it.t) * POLAR_BINS + int'(it.p);
                    thr = (longint'({48'd0, m_peak_ratio}) * m_max_count) >> 16;
                    e.cell_votes = m_votes[a];
                    e.is_peak    = (m_votes[a] >= thr);
                    if (e.is_peak) n_peak_hits++;
                end
            end
            OP_TEST: begin
                n_test++;
                c8 = longint'({58'd0, it.r}) * m_rho_step;
                if (in_rng && c8 < (64'd1 << 29)) begin
                    gap = mag(plane_dot(it.x, it.y, it.z, it.t, it.p) - longint'(c8 << SHIFT));
                    e.on_plane = (gap < (longint'({48'd0, m_dist_limit}) <<< 30));
                    if (e.on_plane) n_plane_hits++;
                end
            end
            default: begin
                n_clear++;
                foreach (m_votes[i]) m_votes[i] = '0;
                m_max_count = '0;
            end
        endcase
        e.peak_votes = m_max_count;
        expected_results = {expected_results, e};
    endtask

    // Item driver: the next pending item goes out at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && (!item_ch.valid || item_took)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                t_hough_item it;
                it = pending_items.pop_front();
                item_ch.valid     <= 1'b1;
                item_ch.op        <= it.op;
                item_ch.x_mm      <= it.x;
                item_ch.y_mm      <= it.y;
                item_ch.z_mm      <= it.z;
                item_ch.azim_idx  <= it.t;
                item_ch.polar_idx <= it.p;
                item_ch.range_idx <= it.r;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Accepted items feed the predictor.
    always @(posedge i_clk) begin
        item_took <= item_ch.valid && item_ch.ready;
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            t_hough_item it;
            it.op = t_op'(item_ch.op);
            it.x  = item_ch.x_mm;
            it.y  = item_ch.y_mm;
            it.z  = item_ch.z_mm;
            it.t  = item_ch.azim_idx;
            it.p  = item_ch.polar_idx;
            it.r  = item_ch.range_idx;
            predict(it);
        end
    end

    // Result receiver with random back-pressure and an occasional long hold.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else if (hold_grant != hold_req) begin
            hold_grant = hold_req;
            hold_left  = HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Result monitor: compare against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result votes=%0d peak=%0d", res_ch.cell_votes,
                             res_ch.peak_votes);
            end else begin
                t_hough_result e;
                e = expected_results.pop_front();
                if (res_ch.cell_votes !== e.cell_votes || res_ch.peak_votes !== e.peak_votes ||
                    res_ch.is_peak !== e.is_peak || res_ch.on_plane !== e.on_plane) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: exp votes=%0d max=%0d peak=%0b plane=%0b, ",
                                  "got %0d %0d %0b %0b"},
                                 e.cell_votes, e.peak_votes, e.is_peak, e.on_plane,
                                 res_ch.cell_votes, res_ch.peak_votes, res_ch.is_peak,
                                 res_ch.on_plane);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        int quiet;
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Timeout with %0d results outstanding", expected_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Register write; the model copy updates at the handshake.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_RHO_SCALE:  m_rho_scale  = value;
            CFG_RHO_STEP:   m_rho_step   = value[23:0];
            CFG_DIST_LIMIT: m_dist_limit = value[15:0];
            default:        m_peak_ratio = value[15:0];
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_item(input t_op op, input t_coord x, input t_coord y, input t_coord z,
                             input int t, input int p, input int r);
        t_hough_item it;
        it.op = op;
        it.x  = x;
        it.y  = y;
        it.z  = z;
        it.t  = t[5:0];
        it.p  = p[4:0];
        it.r  = r[5:0];
        pending_items = {pending_items, it};
    endtask

    // Wait for every item to go out and every result to come back.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
    endtask

    // Coordinate within +-span, now and then anywhere in the full range.
    function automatic t_coord rand_coord(int span);
        if ($urandom_range(9) == 0) return t_coord'($urandom);
        return t_coord'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Random mix: votes mostly on a few planes so cells build up, reads and tests aimed
    // at cells the points actually hit, and some stray addresses.
    task automatic random_items(input int count, input int span);
        t_coord          x;
        t_coord          y;
        t_coord          z;
        int              t;
        int              p;
        int              r;
        int              pick;
        longint unsigned bin;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            x = rand_coord(span);
            y = rand_coord(span);
            z = ($urandom_range(2) == 0) ? rand_coord(span)
                                          : t_coord'((span / 4) * int'($urandom_range(1, 2)));
            t = $urandom_range(AZIM_BINS - 1);
            p = ($urandom_range(1) == 0) ? 0 : $urandom_range(POLAR_BINS - 1);
            bin = rho_bin_of(x, y, z, t, p);
            r = (bin < RANGE_BINS) ? int'(bin) : $urandom_range(RANGE_BINS - 1);
            if ($urandom_range(19) == 0) r = $urandom_range(RANGE_BINS, 63);
            if (pick < 50) push_item(OP_VOTE, x, y, z, t, p, r);
            else if (pick < 75) push_item(OP_READ, x, y, z, t, p, r);
            else push_item(OP_TEST, x, y, z, t, p,
                           ($urandom_range(1) == 0) ? r : $urandom_range(63));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.op = '0;
        item_ch.x_mm = '0;
        item_ch.y_mm = '0;
        item_ch.z_mm = '0;
        item_ch.azim_idx = '0;
        item_ch.polar_idx = '0;
        item_ch.range_idx = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        item_took = 1'b0;
        send_idle = 37;
        recv_idle = 50;
        hold_req = 0;
        hold_grant = 0;
        hold_left = 0;
        mismatches = 0;
        n_vote = 0; n_read = 0; n_test = 0; n_clear = 0; n_peak_hits = 0; n_plane_hits = 0;
        m_rho_scale  = RHO_SCALE_RST;
        m_rho_step   = RHO_STEP_RST;
        m_dist_limit = DIST_LIM_RST;
        m_peak_ratio = PEAK_RATIO_RST;
        m_max_count  = '0;
        foreach (m_votes[i]) m_votes[i] = '0;
        for (int i = 0; i < AZIM_BINS; i++) trig_pair(i, AZIM_BINS, sin_t[i], cos_t[i]);
        for (int i = 0; i < POLAR_BINS; i++) trig_pair(i, 2 * POLAR_BINS, sin_p[i], cos_p[i]);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under reset register values.
        push_item(OP_READ, 0, 0, 0, 5, 3, 2);              // empty accumulator reads as peak
        push_item(OP_VOTE, 0, 0, 0, 0, 0, 0);              // zero point leaves store alone
        push_item(OP_VOTE, 100, 200, 1500, 0, 0, 0);
        push_item(OP_VOTE, -100, 50, 1500, 0, 0, 0);
        push_item(OP_VOTE, 524287, -524288, 524287, 0, 0, 0);  // extremes, mostly out of rho
        push_item(OP_VOTE, 3, -2, 1, 0, 0, 0);
        push_item(OP_READ, 0, 0, 0, 0, 0, int'(rho_bin_of(0, 0, 1500, 0, 0)));
        push_item(OP_READ, 0, 0, 0, 63, 31, 0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 63);             // rho index out of range
        push_item(OP_READ, 0, 0, 0, 10, 7, 32);
        push_item(OP_TEST, 0, 0, 1500, 0, 0, int'(rho_bin_of(0, 0, 1500, 0, 0)));
        push_item(OP_TEST, 0, 0, 1600, 0, 0, 8);           // exactly on the cell plane
        push_item(OP_TEST, -524288, 524287, -524288, 63, 31, 31);
        push_item(OP_TEST, 0, 0, 0, 0, 0, 0);
        push_item(OP_TEST, 0, 0, 1500, 0, 0, 40);          // cell out of range
        push_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        push_item(OP_READ, 0, 0, 0, 0, 0, int'(rho_bin_of(0, 0, 1500, 0, 0)));
        push_item(OP_VOTE, -7, 9, -11, 0, 0, 0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // Phase one: defaults, long receiver hold while items keep coming.
        hold_req = hold_req + 1;
        random_items(90, 6000);
        wait_idle();

        // Phase two: one bin per millimetre, widest limits, idling swapped.
        write_reg(CFG_RHO_SCALE, 32'd1 << 24);
        write_reg(CFG_RHO_STEP, 32'd256);
        write_reg(CFG_DIST_LIMIT, 32'd65535);
        write_reg(CFG_PEAK_RATIO, 32'd65535);
        send_idle = 50;
        recv_idle = 37;
        random_items(45, 24);
        push_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        random_items(45, 24);
        wait_idle();

        // Phase three: zero scale and largest step, then the opposite extremes.
        write_reg(CFG_RHO_SCALE, 32'd0);
        write_reg(CFG_RHO_STEP, 32'hFF_FFFF);
        write_reg(CFG_DIST_LIMIT, 32'd0);
        write_reg(CFG_PEAK_RATIO, 32'd0);
        send_idle = 0;
        recv_idle = 0;
        push_item(OP_VOTE, 9, 9, 9, 0, 0, 0);
        push_item(OP_READ, 0, 0, 0, 4, 4, 0);
        push_item(OP_TEST, 9, 9, 9, 4, 4, 31);
        push_item(OP_TEST, 9, 9, 9, 4, 4, 0);
        push_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        wait_idle();
        write_reg(CFG_RHO_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_RHO_STEP, 32'd1);
        write_reg(CFG_DIST_LIMIT, 32'd5);
        write_reg(CFG_PEAK_RATIO, 32'd32768);
        random_items(85, 4000);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d votes, %0d reads (%0d peaks), %0d tests (%0d on plane), %0d clears",
                 n_vote, n_read, n_peak_hits, n_test, n_plane_hits, n_clear);
        $display("Register settings: reset values, widest bins and limits, zero and full scale");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
